### src/tglsm_pkg.sv
// package: types, constants and band tables for the tuner gain to lna state mapper
`timescale 1ns / 1ps
package tglsm_pkg;

   localparam int NumEntries = 10;

   localparam logic [9:0]  GAIN_CEILING   = 10'd1020;
   localparam logic [6:0]  BASE_REDUCTION = 7'd102;
   localparam logic [7:0]  IF_MIN         = 8'd20;
   localparam logic [7:0]  IF_MAX         = 8'd59;
   localparam logic [7:0]  RECIP_TEN      = 8'd205;   // 2^11 / 10, exact for values below 1029
   localparam logic [7:0]  RECIP_THREE    = 8'd171;   // 2^9 / 3, exact for values below 512
   localparam logic [3:0]  NOMATCH_STATE  = 4'd3;
   localparam logic [5:0]  NOMATCH_IF     = 6'd30;

   localparam logic [30:0] EDGE_LOW_HZ  = 31'd60000000;
   localparam logic [30:0] EDGE_MID_HZ  = 31'd420000000;
   localparam logic [30:0] EDGE_HIGH_HZ = 31'd1000000000;

   // tuner variant codes
   localparam logic [1:0] VARIANT_A = 2'd0;
   localparam logic [1:0] VARIANT_B = 2'd1;

   // register indexes
   localparam logic REG_TUNER_VARIANT = 1'b0;

   // band row codes
   localparam logic [3:0] ROW_A_LOW  = 4'd0;
   localparam logic [3:0] ROW_A_MID  = 4'd1;
   localparam logic [3:0] ROW_A_HIGH = 4'd2;
   localparam logic [3:0] ROW_B_LOW  = 4'd3;
   localparam logic [3:0] ROW_B_MID  = 4'd4;
   localparam logic [3:0] ROW_B_HIGH = 4'd5;
   localparam logic [3:0] ROW_C_VLOW = 4'd6;
   localparam logic [3:0] ROW_C_LOW  = 4'd7;
   localparam logic [3:0] ROW_C_MID  = 4'd8;
   localparam logic [3:0] ROW_C_HIGH = 4'd9;

   typedef struct packed {
      logic [30:0] tune_frequency_hz;
      logic [9:0]  gain_tenths_db;
   } req_word_type;

   typedef struct packed {
      logic [3:0] lna_state;
      logic [5:0] if_reduction_db;
      logic       matched;
   } rsp_word_type;

   typedef logic [6:0] entry_type;
   typedef entry_type [0:NumEntries-1] row_entries_type;

   function automatic logic [3:0] row_select(input logic [1:0] variant,
                                             input logic [30:0] freq);
      logic [1:0] band;
      logic [3:0] row;
      begin
         band = (freq < EDGE_MID_HZ) ? 2'd0 : ((freq < EDGE_HIGH_HZ) ? 2'd1 : 2'd2);
         if (variant == VARIANT_A) begin
            row = ROW_A_LOW + {2'b00, band};
         end else if (variant == VARIANT_B) begin
            row = ROW_B_LOW + {2'b00, band};
         end else if (freq < EDGE_LOW_HZ) begin
            row = ROW_C_VLOW;
         end else begin
            row = ROW_C_LOW + {2'b00, band};
         end
         return row;
      end
   endfunction

   function automatic logic [3:0] row_count(input logic [3:0] row);
      logic [3:0] cnt;
      begin
         case (row)
            ROW_A_LOW:  cnt = 4'd4;
            ROW_A_MID:  cnt = 4'd4;
            ROW_A_HIGH: cnt = 4'd4;
            ROW_B_LOW:  cnt = 4'd9;
            ROW_B_MID:  cnt = 4'd6;
            ROW_B_HIGH: cnt = 4'd6;
            ROW_C_VLOW: cnt = 4'd7;
            ROW_C_LOW:  cnt = 4'd10;
            ROW_C_MID:  cnt = 4'd10;
            ROW_C_HIGH: cnt = 4'd9;
            default:    cnt = 4'd0;
         endcase
         return cnt;
      end
   endfunction

   // slots past the row count are never looked at
   function automatic row_entries_type row_entries(input logic [3:0] row);
      row_entries_type e;
      begin
         case (row)
            ROW_A_LOW:  e = '{7'd0, 7'd24, 7'd19, 7'd43, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
            ROW_A_MID:  e = '{7'd0, 7'd7, 7'd19, 7'd26, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
            ROW_A_HIGH: e = '{7'd0, 7'd5, 7'd19, 7'd24, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
            ROW_B_LOW:  e = '{7'd0, 7'd10, 7'd15, 7'd21, 7'd24, 7'd34, 7'd39, 7'd45, 7'd64,
                              7'd0};
            ROW_B_MID:  e = '{7'd0, 7'd7, 7'd10, 7'd17, 7'd22, 7'd41, 7'd0, 7'd0, 7'd0, 7'd0};
            ROW_B_HIGH: e = '{7'd0, 7'd5, 7'd21, 7'd15, 7'd15, 7'd32, 7'd0, 7'd0, 7'd0, 7'd0};
            ROW_C_VLOW: e = '{7'd0, 7'd6, 7'd12, 7'd18, 7'd37, 7'd42, 7'd61, 7'd0, 7'd0, 7'd0};
            ROW_C_LOW:  e = '{7'd0, 7'd6, 7'd12, 7'd18, 7'd20, 7'd26, 7'd32, 7'd38, 7'd57,
                              7'd62};
            ROW_C_MID:  e = '{7'd0, 7'd7, 7'd13, 7'd19, 7'd20, 7'd27, 7'd33, 7'd39, 7'd45,
                              7'd64};
            ROW_C_HIGH: e = '{7'd0, 7'd6, 7'd12, 7'd20, 7'd26, 7'd32, 7'd38, 7'd43, 7'd62,
                              7'd0};
            default:    e = '{default: 7'd0};
         endcase
         return e;
      end
   endfunction

endpackage

### src/tuner_gain_to_lna_state_mapper_core.sv
// path: a taken word is held in the input register, mapped combinationally, and registered for rsp
// throughput: one word per cycle, set by the input register feeding the mapping logic
// the result register frees as it is taken, so words flow with no bubble; under a
// held rsp_stall both registers fill and req_stall rises
// reset: synchronous, active high; clears both valid flags and sets tuner variant to 0
`timescale 1ns / 1ps
module tuner_gain_to_lna_state_mapper_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  tglsm_pkg::req_word_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output tglsm_pkg::rsp_word_type rsp_data,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [2:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import tglsm_pkg::*;

   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_word_type s1_data_ff;
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_word_type out_data_ff;
   rsp_word_type map_word;
   logic [1:0]   tuner_variant;
   logic         req_take;
   logic         s1_move;

   tglsm_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .tuner_variant (tuner_variant)
   );

   tglsm_map u_map (
      .tuner_variant (tuner_variant),
      .req_word      (s1_data_ff),
      .rsp_word      (map_word)
   );

   assign s1_move   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = req_take || (s1_valid_ff && !s1_move);
      out_valid_in = s1_move || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_data;
      end
      if (s1_move) begin
         out_data_ff <= map_word;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

### src/tglsm_csr.sv
// apb-style register file holding the tuner variant
`timescale 1ns / 1ps
module tglsm_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [1:0]  tuner_variant
);
   import tglsm_pkg::*;

   logic [1:0] variant_ff;
   logic [1:0] variant_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TUNER_VARIANT);

   always_comb begin
      variant_in = variant_ff;
      if (wr_en) begin
         variant_in = pwdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff <= VARIANT_A;
      end else begin
         variant_ff <= variant_in;
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == REG_TUNER_VARIANT) begin
         prdata = {30'd0, variant_ff};
      end
   end

   assign tuner_variant = variant_ff;

endmodule

### src/tglsm_map.sv
// combinational gain to lna state mapping for one word
`timescale 1ns / 1ps
module tglsm_map (
   input  logic [1:0]              tuner_variant,
   input  tglsm_pkg::req_word_type req_word,
   output tglsm_pkg::rsp_word_type rsp_word
);
   import tglsm_pkg::*;

   logic [9:0]          gain_sat;
   logic [17:0]         gain_prod;
   logic [6:0]          reduction;
   logic [14:0]         red_prod;
   logic [5:0]          limit;
   logic [3:0]          row;
   logic [3:0]          cnt;
   row_entries_type     entries;
   logic [NumEntries-1:0] hit;
   logic [3:0]          pick;
   logic                found;
   entry_type           sel_entry;
   logic signed [7:0]   ifr;
   logic [7:0]          ifr_clamped;

   always_comb begin
      gain_sat  = (req_word.gain_tenths_db > GAIN_CEILING) ? GAIN_CEILING
                                                            : req_word.gain_tenths_db;
      // divide by ten through the reciprocal
      gain_prod = {8'd0, gain_sat} * {10'd0, RECIP_TEN};
      reduction = BASE_REDUCTION - gain_prod[17:11];
      red_prod  = {8'd0, reduction} * {7'd0, RECIP_THREE};
      limit     = red_prod[14:9];
   end

   always_comb begin
      row     = row_select(tuner_variant, req_word.tune_frequency_hz);
      cnt     = row_count(row);
      entries = row_entries(row);
      for (int i = 0; i < NumEntries; i++) begin
         hit[i] = (4'(i) < cnt) && (entries[i] >= {1'b0, limit});
      end
   end

   // first qualifying slot wins
   always_comb begin
      pick  = 4'd0;
      found = 1'b0;
      for (int i = NumEntries - 1; i >= 0; i--) begin
         if (hit[i]) begin
            pick  = 4'(i);
            found = 1'b1;
         end
      end
      sel_entry = entries[pick];
      ifr       = $signed({1'b0, reduction}) - $signed({1'b0, sel_entry});
      if (ifr < $signed(IF_MIN)) begin
         ifr_clamped = IF_MIN;
      end else if (ifr > $signed(IF_MAX)) begin
         ifr_clamped = IF_MAX;
      end else begin
         ifr_clamped = ifr;
      end
   end

   always_comb begin
      if (found) begin
         rsp_word.lna_state       = pick;
         rsp_word.if_reduction_db = ifr_clamped[5:0];
         rsp_word.matched         = 1'b1;
      end else begin
         rsp_word.lna_state       = NOMATCH_STATE;
         rsp_word.if_reduction_db = NOMATCH_IF;
         rsp_word.matched         = 1'b0;
      end
   end

endmodule

### sim/tb_tuner_gain_to_lna_state_mapper_core.sv
// testbench for the tuner gain to lna state mapper: random and directed words against a predictor
`timescale 1ns / 1ps
module tb_tuner_gain_to_lna_state_mapper_core;

   localparam int GAIN_SAT       = 1020;
   localparam int REDUCTION_BASE = 102;
   localparam int IF_FLOOR       = 20;
   localparam int IF_CEIL        = 59;
   localparam int NOMATCH_LNA    = 3;
   localparam int NOMATCH_IF_DB  = 30;

   localparam longint FREQ_EDGE_C  = 60000000;
   localparam longint FREQ_EDGE_LO = 420000000;
   localparam longint FREQ_EDGE_HI = 1000000000;
   localparam longint FREQ_TOP     = 2147483647;

   // rows of the threshold table, in the order they are filled below
   localparam int ROW_FIRST_A  = 0;
   localparam int ROW_FIRST_B  = 3;
   localparam int ROW_C_BOTTOM = 6;
   localparam int ROW_FIRST_C  = 7;

   localparam logic [2:0] CSR_ADDR_VARIANT = 3'd0;
   localparam logic [2:0] CSR_ADDR_UNUSED  = 3'd4;

   localparam int ITEMS_PER_PHASE = 140;
   localparam int LONG_HOLD       = 120;
   localparam int TAIL_CYCLES     = 8;
   localparam int WATCHDOG_LIMIT  = 3000;

   typedef enum logic [1:0] {
      TUNER_SET_A     = 2'd0,
      TUNER_SET_B     = 2'd1,
      TUNER_SET_C     = 2'd2,
      TUNER_SET_SPARE = 2'd3
   } tuner_set_e;

   class lna_map_checker;
      tuner_set_e                variant;
      tglsm_pkg::rsp_word_type   pending_results[$];
      int                        error_count;
      int                        entry_count[10];
      int                        thresholds[10][10];

      function new();
         variant = TUNER_SET_A;
         error_count = 0;
         entry_count = '{4, 4, 4, 9, 6, 6, 7, 10, 10, 9};
         thresholds = '{
            '{0, 24, 19, 43, 0, 0, 0, 0, 0, 0},
            '{0, 7, 19, 26, 0, 0, 0, 0, 0, 0},
            '{0, 5, 19, 24, 0, 0, 0, 0, 0, 0},
            '{0, 10, 15, 21, 24, 34, 39, 45, 64, 0},
            '{0, 7, 10, 17, 22, 41, 0, 0, 0, 0},
            '{0, 5, 21, 15, 15, 32, 0, 0, 0, 0},
            '{0, 6, 12, 18, 37, 42, 61, 0, 0, 0},
            '{0, 6, 12, 18, 20, 26, 32, 38, 57, 62},
            '{0, 7, 13, 19, 20, 27, 33, 39, 45, 64},
            '{0, 6, 12, 20, 26, 32, 38, 43, 62, 0}
         };
      endfunction

      function tglsm_pkg::rsp_word_type map_gain(tglsm_pkg::req_word_type w);
         tglsm_pkg::rsp_word_type r;
         longint freq;
         int gain, reduction, floor_db, band, row, i, ifr;
         bit found;
         freq = longint'(w.tune_frequency_hz);
         gain = int'(w.gain_tenths_db);
         if (gain > GAIN_SAT) gain = GAIN_SAT;
         reduction = REDUCTION_BASE - gain / 10;
         floor_db = reduction / 3;
         band = (freq < FREQ_EDGE_LO) ? 0 : ((freq < FREQ_EDGE_HI) ? 1 : 2);
         case (variant)
            TUNER_SET_A: row = ROW_FIRST_A + band;
            TUNER_SET_B: row = ROW_FIRST_B + band;
            // set c and the spare code share the four-band table
            default:     row = (freq < FREQ_EDGE_C) ? ROW_C_BOTTOM : ROW_FIRST_C + band;
         endcase
         r.lna_state = 4'(NOMATCH_LNA);
         r.if_reduction_db = 6'(NOMATCH_IF_DB);
         r.matched = 1'b0;
         found = 1'b0;
         for (i = 0; i < entry_count[row]; i++) begin
            if (!found && thresholds[row][i] >= floor_db) begin
               found = 1'b1;
               ifr = reduction - thresholds[row][i];
               if (ifr < IF_FLOOR) ifr = IF_FLOOR;
               if (ifr > IF_CEIL) ifr = IF_CEIL;
               r.lna_state = 4'(i);
               r.if_reduction_db = 6'(ifr);
               r.matched = 1'b1;
            end
         end
         return r;
      endfunction

      task report(string msg);
         $display("mismatch at %0t ns: %s", $time, msg);
         error_count++;
      endtask

      function void note_request(tglsm_pkg::req_word_type w);
         pending_results.push_back(map_gain(w));
      endfunction

      task check_result(tglsm_pkg::rsp_word_type got);
         tglsm_pkg::rsp_word_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("result word %h with nothing pending", got));
         end else begin
            want = pending_results.pop_front();
            if (got.lna_state !== want.lna_state)
               report($sformatf("lna_state %0d, want %0d", got.lna_state, want.lna_state));
            if (got.if_reduction_db !== want.if_reduction_db)
               report($sformatf("if_reduction_db %0d, want %0d",
                                got.if_reduction_db, want.if_reduction_db));
            if (got.matched !== want.matched)
               report($sformatf("matched %0d, want %0d", got.matched, want.matched));
         end
      endtask
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   tglsm_pkg::req_word_type req_data;
   logic                    rsp_valid;
   logic                    rsp_stall;
   tglsm_pkg::rsp_word_type rsp_data;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [2:0]              paddr;
   logic [31:0]             pwdata;
   logic [31:0]             prdata;
   logic                    pready;

   lna_map_checker mapper_check;
   bit             hold_request;
   int             quiet_cycles;

   tuner_gain_to_lna_state_mapper_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // accepted words and returned results go to the checker, and a run with no traffic for too long is ended
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && !req_stall) mapper_check.note_request(req_data);
         if (rsp_valid && !rsp_stall) mapper_check.check_result(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (psel && penable && pready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("** tuner_gain_to_lna_state_mapper_core: FAILED **");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // receiver stalls in segments of random style, plus one long hold on request
   initial begin
      int seg_len, style, i;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            seg_len = $urandom_range(5, 60);
            style = $urandom_range(0, 3);
            // a hold request cuts the segment short
            for (i = 0; i < seg_len && !hold_request; i++) begin
               case (style)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 99) < 25);
                  2: rsp_stall <= ($urandom_range(0, 99) < 65);
                  default: rsp_stall <= i[0];
               endcase
               @(posedge clock);
            end
         end
      end
   end

   task send_word(tglsm_pkg::req_word_type w);
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task idle_sender(int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // let the monitor note the last accepted word first, then wait until nothing is pending
   task wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mapper_check.pending_results.size() != 0) @(posedge clock);
   endtask

   task csr_write(logic [2:0] addr, logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == CSR_ADDR_VARIANT) mapper_check.variant = tuner_set_e'(data[1:0]);
   endtask

   task csr_read(logic [2:0] addr, output logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      data = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task check_variant_readback();
      logic [31:0] rd;
      csr_read(CSR_ADDR_VARIANT, rd);
      if (rd !== {30'd0, mapper_check.variant})
         mapper_check.report($sformatf("tuner_variant reads %h, want %0d",
                                       rd, mapper_check.variant));
   endtask

   // switch tables only once the pipe is empty; a stray write elsewhere must not land
   task select_tables(tuner_set_e s);
      logic [31:0] junk;
      wait_for_results();
      repeat (3) @(posedge clock);
      junk = $urandom;
      csr_write(CSR_ADDR_VARIANT, {junk[31:2], 2'(s)});
      csr_write(CSR_ADDR_UNUSED, $urandom);
      check_variant_readback();
   endtask

   task send_case(tuner_set_e s, logic [30:0] freq, logic [9:0] gain);
      tglsm_pkg::req_word_type w;
      if (s != mapper_check.variant) select_tables(s);
      w.tune_frequency_hz = freq;
      w.gain_tenths_db = gain;
      send_word(w);
   endtask

   function tglsm_pkg::req_word_type random_word();
      tglsm_pkg::req_word_type w;
      longint edges[5];
      longint f;
      edges = '{0, FREQ_EDGE_C, FREQ_EDGE_LO, FREQ_EDGE_HI, FREQ_TOP};
      case ($urandom_range(0, 7))
         0, 1: f = longint'($urandom) & FREQ_TOP;
         2, 3: f = longint'($urandom_range(0, 1500000000));
         4: f = edges[$urandom_range(0, 4)] - longint'($urandom_range(0, 1));
         default: f = edges[$urandom_range(0, 4)] + longint'($urandom_range(0, 4000)) - 2000;
      endcase
      if (f < 0) f = 0;
      if (f > FREQ_TOP) f = FREQ_TOP;
      w.tune_frequency_hz = f[30:0];
      // lean on saturation and the no-match corners
      case ($urandom_range(0, 9))
         4: w.gain_tenths_db = 10'($urandom_range(1015, 1023));
         5: w.gain_tenths_db = 10'($urandom_range(0, 45));
         6: w.gain_tenths_db = 10'($urandom_range(200, 240));
         default: w.gain_tenths_db = 10'($urandom_range(0, 1023));
      endcase
      return w;
   endfunction

   task run_random_phase(int count, bit back_to_back, bit with_hold);
      int burst, i;
      burst = $urandom_range(1, 20);
      for (i = 0; i < count; i++) begin
         if (with_hold && i == count / 5) hold_request = 1'b1;
         if (i == count / 2) wait_for_results();
         send_word(random_word());
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 20);
            if (!back_to_back)
               idle_sender(($urandom_range(0, 19) == 0) ? $urandom_range(10, 30)
                                                        : $urandom_range(0, 4));
         end
      end
   endtask

   initial begin
      tuner_set_e phase_sets[6];
      int p;
      mapper_check = new();
      hold_request = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_variant_readback();

      // directed corners: band edges, gain saturation, no-match rows, spare code
      send_case(TUNER_SET_A, 31'd0, 10'd0);
      send_case(TUNER_SET_A, 31'h7fffffff, 10'd1023);
      send_case(TUNER_SET_A, 31'd419999999, 10'd1021);
      send_case(TUNER_SET_A, 31'd420000000, 10'd1022);
      send_case(TUNER_SET_A, 31'd999999999, 10'd1020);
      send_case(TUNER_SET_A, 31'd1000000000, 10'd0);
      send_case(TUNER_SET_A, 31'd500000000, 10'd219);
      send_case(TUNER_SET_A, 31'd500000000, 10'd220);
      send_case(TUNER_SET_A, 31'd100000000, 10'd500);
      send_case(TUNER_SET_B, 31'd1500000000, 10'd39);
      send_case(TUNER_SET_B, 31'd1500000000, 10'd40);
      send_case(TUNER_SET_B, 31'd300000000, 10'd9);
      send_case(TUNER_SET_SPARE, 31'd59999999, 10'd0);
      send_case(TUNER_SET_SPARE, 31'd60000000, 10'd1023);
      send_case(TUNER_SET_SPARE, 31'd419999999, 10'd300);
      send_case(TUNER_SET_C, 31'd420000000, 10'd600);
      send_case(TUNER_SET_C, 31'd1000000000, 10'd5);
      send_case(TUNER_SET_C, 31'h7fffffff, 10'd1021);

      phase_sets = '{TUNER_SET_B, TUNER_SET_C, TUNER_SET_SPARE,
                     TUNER_SET_A, TUNER_SET_C, TUNER_SET_B};
      for (p = 0; p < 6; p++) begin
         select_tables(phase_sets[p]);
         run_random_phase(ITEMS_PER_PHASE, p == 2, p == 1);
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mapper_check.pending_results.size() != 0)
         mapper_check.report($sformatf("%0d results never arrived",
                                       mapper_check.pending_results.size()));
      if (mapper_check.error_count == 0) begin
         $display("** tuner_gain_to_lna_state_mapper_core: PASSED **");
      end else begin
         $display("** tuner_gain_to_lna_state_mapper_core: FAILED **");
      end
      $finish;
   end

endmodule

### sim.f
src/tglsm_pkg.sv
src/tglsm_csr.sv
src/tglsm_map.sv
src/tuner_gain_to_lna_state_mapper_core.sv
sim/tb_tuner_gain_to_lna_state_mapper_core.sv
